@@ rtl/core/kbd_pkg.sv @@
// Package for the scan code set 1 decoder: flag struct, event codes,
// scan code constants and the US layout key tables. No dependencies.
`timescale 1ns / 1ps

package kbd_pkg;

  // Modifier and lock flags kept in the state memory
  typedef struct packed {
    logic lshift;
    logic rshift;
    logic ctrl;
    logic alt;
    logic caps;
  } kbd_flags_t;

  localparam int FLAGS_W = $bits(kbd_flags_t);

  // One entry holds the flags; a depth of two keeps a one-bit address
  localparam int STATE_DEPTH = 2;
  localparam logic [$clog2(STATE_DEPTH)-1:0] STATE_ADDR = '0;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_CHAR   = 3'd1,
    EV_BACK   = 3'd2,
    EV_ENTER  = 3'd3,
    EV_CLEAR  = 3'd4,
    EV_SWITCH = 3'd5
  } kbd_event_t;

  localparam logic [6:0] SC_BACKSPACE = 7'h0E;
  localparam logic [6:0] SC_ENTER     = 7'h1C;
  localparam logic [6:0] SC_CTRL      = 7'h1D;
  localparam logic [6:0] SC_LSHIFT    = 7'h2A;
  localparam logic [6:0] SC_RSHIFT    = 7'h36;
  localparam logic [6:0] SC_ALT       = 7'h38;
  localparam logic [6:0] SC_CAPS      = 7'h3A;
  localparam logic [6:0] SC_KEY_L     = 7'h26;
  localparam logic [6:0] SC_F1        = 7'h3B;
  localparam logic [6:0] SC_F3        = 7'h3D;

  localparam logic [6:0] CASE_OFFSET  = 7'd32;  // 'a' - 'A'
  localparam logic [6:0] CHAR_LOW_A   = 7'h61;
  localparam logic [6:0] CHAR_LOW_Z   = 7'h7A;

  // Unshifted US layout; zero marks a key with no printable form
  function automatic logic [6:0] plain_map(input logic [6:0] code);
    logic [6:0] c;
    case (code)
      7'h02: c = 7'h31; 7'h03: c = 7'h32; 7'h04: c = 7'h33; 7'h05: c = 7'h34;
      7'h06: c = 7'h35; 7'h07: c = 7'h36; 7'h08: c = 7'h37; 7'h09: c = 7'h38;
      7'h0A: c = 7'h39; 7'h0B: c = 7'h30; 7'h0C: c = 7'h2D; 7'h0D: c = 7'h3D;
      7'h10: c = 7'h71; 7'h11: c = 7'h77; 7'h12: c = 7'h65; 7'h13: c = 7'h72;
      7'h14: c = 7'h74; 7'h15: c = 7'h79; 7'h16: c = 7'h75; 7'h17: c = 7'h69;
      7'h18: c = 7'h6F; 7'h19: c = 7'h70; 7'h1A: c = 7'h5B; 7'h1B: c = 7'h5D;
      7'h1E: c = 7'h61; 7'h1F: c = 7'h73; 7'h20: c = 7'h64; 7'h21: c = 7'h66;
      7'h22: c = 7'h67; 7'h23: c = 7'h68; 7'h24: c = 7'h6A; 7'h25: c = 7'h6B;
      7'h26: c = 7'h6C; 7'h27: c = 7'h3B; 7'h28: c = 7'h27; 7'h29: c = 7'h60;
      7'h2B: c = 7'h5C;
      7'h2C: c = 7'h7A; 7'h2D: c = 7'h78; 7'h2E: c = 7'h63; 7'h2F: c = 7'h76;
      7'h30: c = 7'h62; 7'h31: c = 7'h6E; 7'h32: c = 7'h6D; 7'h33: c = 7'h2C;
      7'h34: c = 7'h2E; 7'h35: c = 7'h2F;
      7'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // Shifted forms of digits and punctuation; zero means keep the plain form
  function automatic logic [6:0] shift_map(input logic [6:0] code);
    logic [6:0] c;
    case (code)
      7'h02: c = 7'h21; 7'h03: c = 7'h40; 7'h04: c = 7'h23; 7'h05: c = 7'h24;
      7'h06: c = 7'h25; 7'h07: c = 7'h5E; 7'h08: c = 7'h26; 7'h09: c = 7'h2A;
      7'h0A: c = 7'h28; 7'h0B: c = 7'h29; 7'h0C: c = 7'h5F; 7'h0D: c = 7'h2B;
      7'h1A: c = 7'h7B; 7'h1B: c = 7'h7D;
      7'h27: c = 7'h3A; 7'h28: c = 7'h22; 7'h29: c = 7'h7E; 7'h2B: c = 7'h7C;
      7'h33: c = 7'h3C; 7'h34: c = 7'h3E; 7'h35: c = 7'h3F;
      7'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/kbd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module kbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read returns the old contents on a same-address write
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/kbd_decode.sv @@
// Combinational key decode: current flags and scan byte in, updated flags
// and one event out. Uses kbd_pkg for tables, codes and the flag struct.
`timescale 1ns / 1ps

module kbd_decode (
  input  logic [7:0]                scan_byte,
  input  kbd_pkg::kbd_flags_t       cur,
  output kbd_pkg::kbd_flags_t       nxt,
  output kbd_pkg::kbd_event_t       ev,
  output logic [6:0]                ch,
  output logic [1:0]                term
);

  logic [6:0] code;
  logic [6:0] pc;
  logic [6:0] sc;
  logic [6:0] fdiff;
  logic       shift;
  logic       letter;

  assign code   = scan_byte[6:0];
  assign shift  = cur.lshift | cur.rshift;
  assign pc     = kbd_pkg::plain_map(code);
  assign sc     = kbd_pkg::shift_map(code);
  assign fdiff  = code - kbd_pkg::SC_F1;
  assign letter = (pc >= kbd_pkg::CHAR_LOW_A) && (pc <= kbd_pkg::CHAR_LOW_Z);

  always_comb begin
    nxt  = cur;
    ev   = kbd_pkg::EV_NONE;
    ch   = '0;
    term = '0;
    if (scan_byte[7]) begin
      // release: drop the matching modifier
      case (code)
        kbd_pkg::SC_LSHIFT: nxt.lshift = 1'b0;
        kbd_pkg::SC_RSHIFT: nxt.rshift = 1'b0;
        kbd_pkg::SC_CTRL:   nxt.ctrl   = 1'b0;
        kbd_pkg::SC_ALT:    nxt.alt    = 1'b0;
        default: ;
      endcase
    end else if (code == kbd_pkg::SC_CAPS) begin
      nxt.caps = ~cur.caps;
    end else if (code == kbd_pkg::SC_RSHIFT) begin
      nxt.rshift = 1'b1;
    end else if (code == kbd_pkg::SC_LSHIFT) begin
      nxt.lshift = 1'b1;
    end else if (code == kbd_pkg::SC_CTRL) begin
      nxt.ctrl = 1'b1;
    end else if (code == kbd_pkg::SC_ALT) begin
      nxt.alt = 1'b1;
    end else if (cur.ctrl && !shift && code == kbd_pkg::SC_KEY_L) begin
      ev = kbd_pkg::EV_CLEAR;
    end else if (cur.alt && !cur.ctrl && !shift &&
                 (code inside {[kbd_pkg::SC_F1:kbd_pkg::SC_F3]})) begin
      ev   = kbd_pkg::EV_SWITCH;
      term = fdiff[1:0];
    end else if (code == kbd_pkg::SC_BACKSPACE) begin
      ev = kbd_pkg::EV_BACK;
    end else if (code == kbd_pkg::SC_ENTER) begin
      ev = kbd_pkg::EV_ENTER;
    end else if (pc != 7'h00) begin
      ev = kbd_pkg::EV_CHAR;
      if (letter && (cur.caps != shift) && !cur.alt && !cur.ctrl) begin
        ch = pc - kbd_pkg::CASE_OFFSET;
      end else if (shift && !cur.ctrl && !cur.alt && sc != 7'h00) begin
        ch = sc;
      end else begin
        ch = pc;
      end
    end
  end

endmodule

@@ rtl/core/keyboard_scancode_to_ascii_core.sv @@
// Top level of the scan code set 1 to ASCII decoder.
// Depends on kbd_pkg, kbd_ram and kbd_decode.
`timescale 1ns / 1ps

// Usage
//   Input channel: in_valid / in_stall with scan_byte, one set 1 byte per
//   item; bit 7 set marks a key release. An item is taken at a rising edge
//   with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with event_res, ascii and
//   terminal_index; exactly one result item per input item, in order.
//   The flags are read at the accepting edge, then decoded and registered
//   into the output register when the read stage advances. Throughput:
//   one item per cycle while the output channel is not stalled, set by the
//   read-modify-write of the single flag entry in the state RAM; a forwarding
//   register covers a write-back that lands on the same edge as the next read.
//   Stall: while out_stall holds a full output register, the item in the
//   read stage waits and in_stall rises; the output payload holds.
//   Reset (rst, synchronous): empties both stages and clears the valid bit
//   of the flag entry, so all modifiers and caps lock read as released/off
//   on the first item after reset. No clearing pass is needed.
//   Extended 0xE0/0xE1 prefixes decode as plain releases and give no event.
module keyboard_scancode_to_ascii_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] scan_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] event_res,
  output logic [6:0] ascii,
  output logic [1:0] terminal_index
);

  // read stage: item waiting for its flags from the RAM
  logic                 s1_valid;
  logic [7:0]           s1_byte;
  logic                 s1_hit;     // write-back landed on this item's read edge
  logic                 s1_adv;
  logic                 in_take;

  // flags forwarding and RAM valid bit
  kbd_pkg::kbd_flags_t  fwd_flags;
  logic                 mem_valid;
  logic [kbd_pkg::FLAGS_W-1:0] ram_rdata;
  kbd_pkg::kbd_flags_t  cur_flags;
  kbd_pkg::kbd_flags_t  new_flags;

  // decode results
  kbd_pkg::kbd_event_t  dec_ev;
  logic [6:0]           dec_ch;
  logic [1:0]           dec_term;

  // output register
  kbd_pkg::kbd_event_t  out_event;
  logic [6:0]           out_ascii;
  logic [1:0]           out_term;

  // advance the read stage whenever the output register is free or leaving
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  kbd_ram #(
    .WIDTH (kbd_pkg::FLAGS_W),
    .DEPTH (kbd_pkg::STATE_DEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (kbd_pkg::STATE_ADDR),
    .wdata (new_flags),
    .re    (in_take),
    .raddr (kbd_pkg::STATE_ADDR),
    .rdata (ram_rdata)
  );

  // pick the freshest flags: forwarded, stored, or reset value
  always_comb begin
    if (s1_hit) begin
      cur_flags = fwd_flags;
    end else if (mem_valid) begin
      cur_flags = kbd_pkg::kbd_flags_t'(ram_rdata);
    end else begin
      cur_flags = '0;
    end
  end

  kbd_decode u_decode (
    .scan_byte (s1_byte),
    .cur       (cur_flags),
    .nxt       (new_flags),
    .ev        (dec_ev),
    .ch        (dec_ch),
    .term      (dec_term)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_hit    <= 1'b0;
      mem_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
        s1_hit   <= s1_adv;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        mem_valid <= 1'b1;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= scan_byte;
    end
    if (s1_adv) begin
      fwd_flags <= new_flags;
      out_event <= dec_ev;
      out_ascii <= dec_ch;
      out_term  <= dec_term;
    end
  end

  assign event_res      = out_event;
  assign ascii          = out_ascii;
  assign terminal_index = out_term;

  // a character is the only event that carries an ASCII code
  a_ascii_only_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res != kbd_pkg::EV_CHAR) |-> ascii == 7'h00)
    else $error("ascii set on a non-character event");

  // a terminal index only accompanies a switch event
  a_term_only_switch: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res != kbd_pkg::EV_SWITCH) |-> terminal_index == 2'd0)
    else $error("terminal index set on a non-switch event");

  // the input side stalls only with both stages full and the output held
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // an item leaving the read stage always lands in the output register
  a_adv_fills_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("advanced item lost before the output register");

endmodule
